// File: rtl/swrl_pkg.sv
// Package for the sliding window rate limiter: sizes, hash constants, FSM states.
// No dependencies.
package swrl_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int RING_DEPTH    = 64;
    localparam int MAX_PROBES    = 64;
    localparam int CLEAR_LEN     = TABLE_ENTRIES;

    localparam logic [63:0] HASH_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] HASH_PRIME = 64'd1099511628211;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH_MUL,
        ST_HASH_ADD,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_RING_RD,
        ST_RING_CHK,
        ST_FINISH,
        ST_OUT
    } state_t;
endpackage

// File: rtl/swrl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/sliding_window_rate_limiter_top.sv
// Sliding window log rate limiter top level.
// Depends on swrl_pkg and swrl_ram.
//
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    s_key_id s_event_limit s_window_len s_now_time
// m_        out        m_valid/m_ready    m_allowed m_table_full m_events_in_window
//
// One request at a time: hashing takes the 8 key bytes in two steps each (the 64x64
// multiply split into two halves), each step a multiply state and an add state; then a read
// and a check state per probed slot and per ring entry compacted, then a finish state;
// bounded by the single bucket and ring RAM ports. After reset a clearing pass over all
// TABLE_ENTRIES slots empties the bucket table; s_ready stays low meanwhile. A result
// waits in an output register; the next request is taken once it has been delivered.
module sliding_window_rate_limiter_top #(
    parameter int TABLE_ENTRIES = swrl_pkg::TABLE_ENTRIES,
    parameter int RING_DEPTH    = swrl_pkg::RING_DEPTH,
    parameter int MAX_PROBES    = swrl_pkg::MAX_PROBES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_key_id,
    input  logic [6:0]  s_event_limit,
    input  logic [31:0] s_window_len,
    input  logic [47:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_allowed,
    output logic        m_table_full,
    output logic [6:0]  m_events_in_window
);
    localparam int SW = $clog2(TABLE_ENTRIES);
    localparam int RW = $clog2(RING_DEPTH);
    localparam int PW = $clog2(MAX_PROBES + 1);
    localparam int BW = 1 + 64 + 7;

    swrl_pkg::state_t state_reg, state_next;

    logic [63:0] key_reg;
    logic [6:0]  limit_reg;
    logic [31:0] window_reg;
    logic [47:0] now_reg;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] part_reg, part_next;
    logic [3:0]  byte_reg, byte_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [PW-1:0] probe_reg, probe_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  idx_reg, idx_next;
    logic [6:0]  kept_reg, kept_next;
    logic        allowed_reg, allowed_next;
    logic        full_reg, full_next;
    logic [6:0]  events_reg, events_next;
    logic [SW-1:0] clr_reg, clr_next;

    logic          b_we;
    logic [SW-1:0] b_waddr, b_raddr;
    logic [BW-1:0] b_wdata, b_rdata;
    logic          r_we;
    logic [SW+RW-1:0] r_waddr, r_raddr;
    logic [47:0]   r_wdata, r_rdata;

    swrl_ram #(.WIDTH(BW), .DEPTH(TABLE_ENTRIES)) u_bucket (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    swrl_ram #(.WIDTH(48), .DEPTH(TABLE_ENTRIES * RING_DEPTH)) u_ring (
        .aclk(aclk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    logic        b_used;
    logic [63:0] b_key;
    logic [6:0]  b_cnt;
    logic [6:0]  lim_sat;
    logic [6:0]  cnt_clamp;
    logic [47:0] age;
    logic        in_win;
    logic [7:0]  cur_byte;

    assign b_used = b_rdata[BW-1];
    assign b_key  = b_rdata[BW-2:7];
    assign b_cnt  = b_rdata[6:0];
    assign lim_sat = (s_event_limit > 7'(RING_DEPTH)) ? 7'(RING_DEPTH) : s_event_limit;
    assign age    = now_reg - r_rdata;
    assign in_win = (r_rdata > now_reg) || (age <= {16'd0, window_reg});
    assign cur_byte = key_reg[{byte_reg[3:1], 3'b000} +: 8];

    always_comb begin
        logic [6:0] c;
        c = (b_cnt > 7'(RING_DEPTH)) ? 7'(RING_DEPTH) : b_cnt;
        cnt_clamp = (c > limit_reg) ? limit_reg : c;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swrl_pkg::ST_CLEAR:     if (clr_reg == SW'(TABLE_ENTRIES - 1))
                                        state_next = swrl_pkg::ST_IDLE;
            swrl_pkg::ST_IDLE:      if (s_valid) state_next = swrl_pkg::ST_HASH_MUL;
            swrl_pkg::ST_HASH_MUL:  state_next = swrl_pkg::ST_HASH_ADD;
            swrl_pkg::ST_HASH_ADD:  state_next = (byte_reg == 4'd15) ? swrl_pkg::ST_PROBE_RD
                                                                     : swrl_pkg::ST_HASH_MUL;
            swrl_pkg::ST_PROBE_RD:  state_next = (probe_reg == PW'(MAX_PROBES))
                                                 ? swrl_pkg::ST_OUT : swrl_pkg::ST_PROBE_CHK;
            swrl_pkg::ST_PROBE_CHK: begin
                if (!b_used || b_key == key_reg) begin
                    state_next = (!b_used || cnt_clamp == 7'd0) ? swrl_pkg::ST_FINISH
                                                                 : swrl_pkg::ST_RING_RD;
                end else begin
                    state_next = swrl_pkg::ST_PROBE_RD;
                end
            end
            swrl_pkg::ST_RING_RD:   state_next = swrl_pkg::ST_RING_CHK;
            swrl_pkg::ST_RING_CHK:  state_next = (idx_reg + 7'd1 == cnt_reg)
                                                 ? swrl_pkg::ST_FINISH : swrl_pkg::ST_RING_RD;
            swrl_pkg::ST_FINISH:    state_next = swrl_pkg::ST_OUT;
            swrl_pkg::ST_OUT:       if (m_ready) state_next = swrl_pkg::ST_IDLE;
            default:                state_next = swrl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        hash_next = hash_reg;
        part_next = part_reg;
        byte_next = byte_reg;
        slot_next = slot_reg;
        probe_next = probe_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        kept_next = kept_reg;
        allowed_next = allowed_reg;
        full_next = full_reg;
        events_next = events_reg;
        clr_next = clr_reg;
        b_we = 1'b0;
        b_waddr = slot_reg;
        b_wdata = '0;
        b_raddr = slot_reg;
        r_we = 1'b0;
        r_waddr = {slot_reg, kept_reg[RW-1:0]};
        r_wdata = r_rdata;
        r_raddr = {slot_reg, idx_reg[RW-1:0]};
        s_ready = 1'b0;
        case (state_reg)
            swrl_pkg::ST_CLEAR: begin
                b_we = 1'b1;
                b_waddr = clr_reg;
                clr_next = clr_reg + SW'(1);
            end
            swrl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                hash_next = swrl_pkg::HASH_BASIS;
                byte_next = '0;
                probe_next = '0;
            end
            swrl_pkg::ST_HASH_MUL: begin
                // even step: xor byte and multiply low 32 bits; odd step: high 32 bits
                if (!byte_reg[0]) begin
                    hash_next = hash_reg ^ {56'd0, cur_byte};
                    part_next = 64'(hash_next[31:0] * swrl_pkg::HASH_PRIME);
                end else begin
                    part_next = part_reg + {32'(hash_reg[63:32] * swrl_pkg::HASH_PRIME[31:0]),
                                            32'd0};
                end
            end
            swrl_pkg::ST_HASH_ADD: begin
                if (byte_reg[0]) hash_next = part_reg;
                byte_next = byte_reg + 4'd1;
                if (byte_reg == 4'd15) slot_next = part_reg[SW-1:0];
            end
            swrl_pkg::ST_PROBE_RD: begin
                if (probe_reg == PW'(MAX_PROBES)) begin
                    allowed_next = 1'b1;
                    full_next = 1'b1;
                    events_next = '0;
                end
            end
            swrl_pkg::ST_PROBE_CHK: begin
                cnt_next = b_used ? cnt_clamp : 7'd0;
                idx_next = '0;
                kept_next = '0;
                if (b_used && b_key != key_reg) begin
                    slot_next = slot_reg + SW'(1);
                    probe_next = probe_reg + PW'(1);
                    b_raddr = slot_reg + SW'(1);
                end
            end
            swrl_pkg::ST_RING_CHK: begin
                if (in_win) begin
                    r_we = 1'b1;
                    kept_next = kept_reg + 7'd1;
                end
                idx_next = idx_reg + 7'd1;
                r_raddr = {slot_reg, idx_next[RW-1:0]};
            end
            swrl_pkg::ST_FINISH: begin
                full_next = 1'b0;
                b_we = 1'b1;
                if (kept_reg >= limit_reg) begin
                    allowed_next = 1'b0;
                    events_next = kept_reg;
                    b_wdata = {1'b1, key_reg, kept_reg};
                end else begin
                    allowed_next = 1'b1;
                    events_next = kept_reg + 7'd1;
                    r_we = 1'b1;
                    r_wdata = now_reg;
                    b_wdata = {1'b1, key_reg, kept_reg + 7'd1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swrl_pkg::ST_CLEAR;
            clr_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
        end
        if (state_reg == swrl_pkg::ST_IDLE && s_valid) begin
            key_reg <= s_key_id;
            limit_reg <= lim_sat;
            window_reg <= s_window_len;
            now_reg <= s_now_time;
        end
        hash_reg <= hash_next;
        part_reg <= part_next;
        byte_reg <= byte_next;
        slot_reg <= slot_next;
        probe_reg <= probe_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        kept_reg <= kept_next;
        allowed_reg <= allowed_next;
        full_reg <= full_next;
        events_reg <= events_next;
    end

    assign m_valid = (state_reg == swrl_pkg::ST_OUT);
    assign m_allowed = allowed_reg;
    assign m_table_full = full_reg;
    assign m_events_in_window = events_reg;
endmodule
